// ===== hw/rtl/fpcl_pkg.sv =====
package fpcl_pkg;

    // Line buffer depth of the receive handler
    localparam int unsigned LINE_BYTES = 32;
    localparam int unsigned COUNT_W    = $clog2(LINE_BYTES);

    // Position in the pattern FAN:<int>-PUMP:<int>
    localparam logic [3:0] PH_HEAD0 = 4'd0;
    localparam logic [3:0] PH_N1    = 4'd4;
    localparam logic [3:0] PH_D1    = 4'd5;
    localparam logic [3:0] PH_LIT2  = 4'd6;
    localparam logic [3:0] PH_N2    = 4'd12;
    localparam logic [3:0] PH_D2    = 4'd13;
    localparam logic [3:0] PH_DONE  = 4'd14;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       command_ok;
        logic [7:0] fan_duty;
        logic [7:0] pump_duty;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Expected character at a literal position of the pattern
    function automatic logic [7:0] lit_char(input logic [3:0] ph);
        logic [7:0] ch;
        case (ph)
            4'd0:    ch = "F";
            4'd1:    ch = "A";
            4'd2:    ch = "N";
            4'd3:    ch = ":";
            4'd6:    ch = "-";
            4'd7:    ch = "P";
            4'd8:    ch = "U";
            4'd9:    ch = "M";
            4'd10:   ch = "P";
            4'd11:   ch = ":";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/fpcl_rx_if.sv =====
interface fpcl_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink (input valid, input rx_char, output ready);
endinterface

// ===== hw/rtl/fpcl_res_if.sv =====
interface fpcl_res_if;
    logic       valid;
    logic       ready;
    logic       command_ok;
    logic [7:0] fan_duty;
    logic [7:0] pump_duty;

    modport source (output valid, output command_ok, output fan_duty, output pump_duty,
                    input ready);
    modport sink (input valid, input command_ok, input fan_duty, input pump_duty,
                  output ready);
endinterface

// ===== hw/rtl/fpcl_match.sv =====
module fpcl_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_char,
    output logic                res_load,
    output fpcl_pkg::result_t   res_data
);

    logic [fpcl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [3:0] phase_reg, phase_next;
    logic       dead_reg, dead_next;
    logic       neg_reg, neg_next;
    logic       dig_reg, dig_next;
    logic [7:0] n1_reg, n1_next;
    logic [7:0] n2_reg, n2_next;
    logic [7:0] fan_reg, fan_next;
    logic [7:0] pump_reg, pump_next;

    // Per-byte working values
    logic [3:0] ph;
    logic       dead, neg, dig, consumed, line_end, ok;
    logic [7:0] n1, n2, dval;

    // Match one byte against the pattern, then handle line end and overflow
    always_comb
    begin
        ph       = phase_reg;
        dead     = dead_reg;
        neg      = neg_reg;
        dig      = dig_reg;
        n1       = n1_reg;
        n2       = n2_reg;
        consumed = 1'b0;
        dval     = rx_char - fpcl_pkg::CH_ZERO;
        line_end = (rx_char == fpcl_pkg::CH_LF) || (rx_char == fpcl_pkg::CH_CR);

        if (line_end || rx_char == fpcl_pkg::CH_NUL)
        begin
            // Close matching: only a number in progress after PUMP: can finish
            if (!dead && ph != fpcl_pkg::PH_DONE)
            begin
                if (ph == fpcl_pkg::PH_D2 && dig)
                begin
                    n2 = neg ? (8'd0 - n2) : n2;
                    ph = fpcl_pkg::PH_DONE;
                end
                else
                begin
                    dead = 1'b1;
                end
            end
        end
        else if (!dead && ph != fpcl_pkg::PH_DONE)
        begin
            if (ph < fpcl_pkg::PH_N1)
            begin
                if (rx_char == fpcl_pkg::lit_char(ph))
                    ph = ph + 4'd1;
                else
                    dead = 1'b1;
                consumed = 1'b1;
            end
            // Skip blanks, take an optional sign
            if (!consumed && (ph == fpcl_pkg::PH_N1 || ph == fpcl_pkg::PH_N2))
            begin
                if (fpcl_pkg::is_blank(rx_char))
                begin
                    consumed = 1'b1;
                end
                else
                begin
                    neg = 1'b0;
                    dig = 1'b0;
                    ph  = ph + 4'd1;
                    if (rx_char == fpcl_pkg::CH_PLUS || rx_char == fpcl_pkg::CH_MINUS)
                    begin
                        neg      = (rx_char == fpcl_pkg::CH_MINUS);
                        consumed = 1'b1;
                    end
                end
            end
            // Accumulate digits modulo 256
            if (!consumed && (ph == fpcl_pkg::PH_D1 || ph == fpcl_pkg::PH_D2))
            begin
                consumed = 1'b1;
                if (fpcl_pkg::is_digit(rx_char))
                begin
                    if (ph == fpcl_pkg::PH_D1)
                        n1 = (n1 << 3) + (n1 << 1) + dval;
                    else
                        n2 = (n2 << 3) + (n2 << 1) + dval;
                    dig = 1'b1;
                end
                else if (!dig)
                begin
                    dead = 1'b1;
                end
                else if (ph == fpcl_pkg::PH_D2)
                begin
                    n2 = neg ? (8'd0 - n2) : n2;
                    ph = fpcl_pkg::PH_DONE;
                end
                else
                begin
                    n1       = neg ? (8'd0 - n1) : n1;
                    ph       = fpcl_pkg::PH_LIT2;
                    consumed = 1'b0;
                end
            end
            // Middle literal -PUMP:
            if (!consumed && ph >= fpcl_pkg::PH_LIT2 && ph < fpcl_pkg::PH_N2)
            begin
                if (rx_char == fpcl_pkg::lit_char(ph))
                    ph = ph + 4'd1;
                else
                    dead = 1'b1;
            end
        end

        ok = !dead && ph == fpcl_pkg::PH_DONE;

        // Default: hold everything
        count_next = count_reg;
        phase_next = phase_reg;
        dead_next  = dead_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        fan_next   = fan_reg;
        pump_next  = pump_reg;

        if (accept)
        begin
            if (line_end || count_reg == fpcl_pkg::COUNT_W'(fpcl_pkg::LINE_BYTES - 1))
            begin
                // Restart the line; on overflow the byte is dropped
                count_next = '0;
                phase_next = fpcl_pkg::PH_HEAD0;
                dead_next  = 1'b0;
                neg_next   = 1'b0;
                dig_next   = 1'b0;
                n1_next    = '0;
                n2_next    = '0;
                if (line_end && ok)
                begin
                    fan_next  = n1;
                    pump_next = n2;
                end
            end
            else
            begin
                count_next = count_reg + 1'b1;
                phase_next = ph;
                dead_next  = dead;
                neg_next   = neg;
                dig_next   = dig;
                n1_next    = n1;
                n2_next    = n2;
            end
        end

        res_load            = accept && line_end;
        res_data.command_ok = ok;
        res_data.fan_duty   = ok ? n1 : fan_reg;
        res_data.pump_duty  = ok ? n2 : pump_reg;
    end

    // Line and level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= fpcl_pkg::PH_HEAD0;
            dead_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            dig_reg   <= 1'b0;
            n1_reg    <= '0;
            n2_reg    <= '0;
            fan_reg   <= '0;
            pump_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            dead_reg  <= dead_next;
            neg_reg   <= neg_next;
            dig_reg   <= dig_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            fan_reg   <= fan_next;
            pump_reg  <= pump_next;
        end
    end

endmodule

// ===== hw/rtl/fpcl_out_reg.sv =====
module fpcl_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fpcl_pkg::result_t   data,
    output logic                room,
    fpcl_res_if.source          res
);

    logic              valid_reg, valid_next;
    fpcl_pkg::result_t data_reg;

    // Free when empty or being drained this cycle
    assign room = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the item until taken
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign res.valid      = valid_reg;
    assign res.command_ok = data_reg.command_ok;
    assign res.fan_duty   = data_reg.fan_duty;
    assign res.pump_duty  = data_reg.pump_duty;

endmodule

// ===== hw/rtl/fan_pump_command_line_parser_core.sv =====
// FAN/PUMP command line parser.
// rx: one received UART byte per item (rx_char). Lines end at CR or LF and
// are matched against FAN:<int>-PUMP:<int>; blanks and a sign may precede
// each number, trailing text is ignored, NUL ends matching, and a line
// longer than 31 bytes restarts with the overflowing byte dropped.
// res: one item per line end: command_ok, and the fan and pump duties in
// force after that line (updated to the low 8 bits of the numbers on a match).
// Throughput: one byte per cycle while rx.ready is high. Each byte is matched
// by the combinational per-byte logic, and a line end's item is registered
// and appears on res the cycle after the byte is accepted.
// The result register holds one item: while it is full and res.ready is
// low, rx.ready drops and no byte is taken; a byte is accepted in the same
// cycle that a held item is taken.
// Reset (rst_n low, asynchronous) empties the result register, clears the
// line state and sets both duties to zero.
module fan_pump_command_line_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    fpcl_rx_if.sink     rx,
    fpcl_res_if.source  res
);

    logic              room;
    logic              accept;
    logic              res_load;
    fpcl_pkg::result_t res_data;

    assign rx.ready = room;
    assign accept   = rx.valid && room;

    fpcl_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_char  (rx.rx_char),
        .res_load (res_load),
        .res_data (res_data)
    );

    fpcl_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .data  (res_data),
        .room  (room),
        .res   (res)
    );

endmodule
